FILE: hdl/mfv_pkg.sv
`default_nettype none

package mfv_pkg;

	localparam int VALUE_W = 64;
	localparam int DEF_DISTINCT_DEPTH = 64;
	localparam int DEF_MAX_ITEMS = 65536;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_EMIT
	} scan_state_t;

endpackage

`default_nettype wire

FILE: hdl/mfv_table.sv
`default_nettype none

module mfv_table import mfv_pkg::*; #(
	parameter int DEPTH = DEF_DISTINCT_DEPTH,
	parameter int WIDTH = VALUE_W + 17
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/mfv_scan.sv
`default_nettype none

module mfv_scan import mfv_pkg::*; #(
	parameter int DISTINCT_DEPTH = DEF_DISTINCT_DEPTH,
	parameter int MAX_ITEMS = DEF_MAX_ITEMS,
	localparam int AW = $clog2(DISTINCT_DEPTH),
	localparam int UW = $clog2(DISTINCT_DEPTH + 1),
	localparam int CNT_W = $clog2(MAX_ITEMS + 1),
	localparam int ENT_W = VALUE_W + CNT_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [VALUE_W-1:0]  in_value,
	input  wire logic                in_last,
	input  wire logic                res_free,
	output logic                     res_valid,
	output logic      [VALUE_W-1:0]  res_value,
	output logic      [CNT_W-1:0]    res_count,
	output logic                     res_overflow,
	output logic                     mem_we,
	output logic      [AW-1:0]       mem_waddr,
	output logic      [ENT_W-1:0]    mem_wdata,
	output logic                     mem_re,
	output logic      [AW-1:0]       mem_raddr,
	input  wire logic [ENT_W-1:0]    mem_rdata
);

	scan_state_t state_q, state_d;

	logic [VALUE_W-1:0] value_q;
	logic               last_q;
	logic [UW-1:0]      iss_q;
	logic               valid_s1;
	logic [AW-1:0]      addr_s1;
	logic               hit_q;
	logic [AW-1:0]      idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [UW-1:0]      used_q;
	logic [VALUE_W-1:0] best_value_q;
	logic [CNT_W-1:0]   best_count_q;
	logic               dropped_q;

	logic [VALUE_W-1:0] rd_value;
	logic [CNT_W-1:0]   rd_count;
	logic               match;
	logic               miss_done;
	logic               issue;
	logic               full;
	logic               upd_ok;
	logic [CNT_W-1:0]   new_cnt;

	assign rd_value  = mem_rdata[CNT_W +: VALUE_W];
	assign rd_count  = mem_rdata[CNT_W-1:0];
	assign match     = (state_q == ST_SCAN) && valid_s1 && (rd_value == value_q);
	assign miss_done = (state_q == ST_SCAN) && !valid_s1 && (iss_q == used_q);
	assign issue     = (state_q == ST_SCAN) && (iss_q < used_q) && !match;
	assign full      = (used_q == UW'(DISTINCT_DEPTH));
	assign upd_ok    = hit_q || !full;

	always_comb begin
		if (!hit_q) begin
			new_cnt = CNT_W'(1);
		end else if (cnt_q == CNT_W'(MAX_ITEMS)) begin
			new_cnt = cnt_q;
		end else begin
			new_cnt = cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match || miss_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = last_q ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_EMIT) && res_free;
		mem_re    = issue;
		mem_raddr = iss_q[AW-1:0];
		mem_we    = (state_q == ST_UPDATE) && upd_ok;
		mem_waddr = hit_q ? idx_q : used_q[AW-1:0];
		mem_wdata = {value_q, new_cnt};
	end

	assign res_value    = best_value_q;
	assign res_count    = best_count_q;
	assign res_overflow = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q    <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (in_ready && in_valid) begin
				iss_q  <= '0;
				hit_q  <= 1'b0;
				last_q <= in_last;
			end else if (issue) begin
				iss_q <= iss_q + UW'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_q <= in_value;
		end
		if (issue) begin
			addr_s1 <= iss_q[AW-1:0];
		end
		if (match) begin
			idx_q <= addr_s1;
			cnt_q <= rd_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			best_value_q <= '0;
			best_count_q <= '0;
			dropped_q    <= 1'b0;
		end else if (state_q == ST_UPDATE) begin
			if (!upd_ok) begin
				dropped_q <= 1'b1;
			end
			if (upd_ok && !hit_q) begin
				used_q <= used_q + UW'(1);
			end
			if (upd_ok && (new_cnt > best_count_q)) begin
				best_count_q <= new_cnt;
				best_value_q <= value_q;
			end
		end else if (res_valid) begin
			used_q       <= '0;
			best_value_q <= '0;
			best_count_q <= '0;
			dropped_q    <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/most_frequent_value_finder.sv
// Streaming mode finder. Values arrive on the s_ channel, one per transfer,
// with s_tlast on the final value of a set. The block counts each distinct
// value in a table of DISTINCT_DEPTH entries held in a memory with one read
// and one write port. A value is looked up by reading the table one entry
// per cycle, from entry 0 up to a match or to the last entry in use; a
// new value goes into the next free entry if there is one.
// After the transfer that carries s_tlast, one result leaves on the m_
// channel after that lookup: the mode value, its count and
// an overflow flag that tells a distinct value was dropped for lack of room.
// The set state is then cleared for the next set.
// The result sits in an output register. The block goes on taking values
// while it waits; a second result waits inside until m_tready frees that
// register, and no input is taken meanwhile.
// Reset clears the set, the best value and count, and the output valid flag.
// The table needs no clearing, since only entries already filled are read.
`default_nettype none

module most_frequent_value_finder import mfv_pkg::*; #(
	parameter int DISTINCT_DEPTH = DEF_DISTINCT_DEPTH,
	parameter int MAX_ITEMS = DEF_MAX_ITEMS,
	localparam int CNT_W = $clog2(MAX_ITEMS + 1),
	localparam int OUT_W = VALUE_W + CNT_W + 1,
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [VALUE_W-1:0]   s_tdata,  // value
	input  wire logic                 s_tlast,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata   // mode_value, mode_count, overflow, zero pad
);

	localparam int AW = $clog2(DISTINCT_DEPTH);
	localparam int ENT_W = VALUE_W + CNT_W;

	logic               res_free;
	logic               res_valid;
	logic [VALUE_W-1:0] res_value;
	logic [CNT_W-1:0]   res_count;
	logic               res_overflow;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENT_W-1:0]   mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [ENT_W-1:0]   mem_rdata;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [M_TDATA_W-1:0] out_word;

	mfv_scan #(
		.DISTINCT_DEPTH(DISTINCT_DEPTH),
		.MAX_ITEMS(MAX_ITEMS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_value(s_tdata),
		.in_last(s_tlast),
		.res_free(res_free),
		.res_valid(res_valid),
		.res_value(res_value),
		.res_count(res_count),
		.res_overflow(res_overflow),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	mfv_table #(
		.DEPTH(DISTINCT_DEPTH),
		.WIDTH(ENT_W)
	) u_table (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign res_free = !out_valid_q || m_tready;

	always_comb begin
		out_word = '0;
		out_word[VALUE_W-1:0] = res_value;
		out_word[VALUE_W +: CNT_W] = res_count;
		out_word[VALUE_W + CNT_W] = res_overflow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= out_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

FILE: sim/most_frequent_value_finder_test.sv
`timescale 1ns / 1ps

module most_frequent_value_finder_test;
	import mfv_pkg::*;

	localparam int CNT_W = $clog2(DEF_MAX_ITEMS + 1);
	localparam int OUT_W = VALUE_W + CNT_W + 1;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = DEF_DISTINCT_DEPTH + 16;
	localparam int RANDOM_ITEMS = 850;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               is_last;
		bit                 hold;
		bit                 steady;
	} column_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   count;
		logic               overflow;
	} mode_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [VALUE_W-1:0]   s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	column_item_t values_to_send[$];
	mode_result_t modes_due[$];

	logic [VALUE_W-1:0] table_values[DEF_DISTINCT_DEPTH];
	int                 table_counts[DEF_DISTINCT_DEPTH];
	int                 entries_used = 0;
	logic [VALUE_W-1:0] lead_value = '0;
	int                 lead_count = 0;
	bit                 table_overflowed = 1'b0;

	int errors = 0;
	int results_seen = 0;
	int values_sent = 0;
	int sets_sent = 0;
	int overflow_sets = 0;
	int send_gap = 0;
	int calm_left = 0;
	int stall_left = 0;
	int cycles = 0;

	most_frequent_value_finder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [VALUE_W-1:0] rand_value();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_value(input logic [VALUE_W-1:0] v, input logic is_last,
			input bit hold = 1'b0, input bit steady = 1'b0);
		column_item_t item;
		item.value = v;
		item.is_last = is_last;
		item.hold = hold;
		item.steady = steady;
		values_to_send.push_back(item);
	endtask

	// Counts one value the way the block does and, on the final value of a set,
	// queues the mode that the block must report before the set is cleared.
	task automatic tally_value(input logic [VALUE_W-1:0] v, input logic is_last);
		int slot;
		mode_result_t res;
		slot = 0;
		while (slot < entries_used && table_values[slot] != v)
			slot++;
		if (slot == entries_used && entries_used >= DEF_DISTINCT_DEPTH) begin
			table_overflowed = 1'b1;
		end else begin
			if (slot == entries_used) begin
				table_values[slot] = v;
				table_counts[slot] = 0;
				entries_used++;
			end
			if (table_counts[slot] < DEF_MAX_ITEMS)
				table_counts[slot]++;
			if (table_counts[slot] > lead_count) begin
				lead_count = table_counts[slot];
				lead_value = v;
			end
		end
		if (is_last) begin
			res.value = lead_value;
			res.count = lead_count[CNT_W-1:0];
			res.overflow = table_overflowed;
			modes_due.push_back(res);
			if (table_overflowed)
				overflow_sets++;
			entries_used = 0;
			lead_value = '0;
			lead_count = 0;
			table_overflowed = 1'b0;
		end
	endtask

	always @(posedge clk) begin : drive_values
		logic offer;
		column_item_t nxt_item;
		if (arst_n) begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				tally_value(s_tdata, s_tlast);
				values_sent++;
				if (s_tlast)
					sets_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (values_to_send.size() > 0
						&& !(values_to_send[0].hold && modes_due.size() > 0)) begin
					nxt_item = values_to_send.pop_front();
					s_tdata <= nxt_item.value;
					s_tlast <= nxt_item.is_last;
					offer = 1'b1;
					if (nxt_item.steady) begin
						send_gap = 0;
					end else if (calm_left > 0) begin
						calm_left--;
						send_gap = 0;
					end else begin
						send_gap = pick_idle();
						if ($urandom_range(0, 39) == 0)
							calm_left = $urandom_range(20, 60);
					end
				end
			end
			s_tvalid <= offer;
		end
	end

	always @(posedge clk) begin : watch_modes
		mode_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (modes_due.size() == 0) begin
					$display("%0t: result with none expected, got %h", $time, m_tdata);
					errors++;
				end else begin
					want = modes_due.pop_front();
					if (m_tdata[VALUE_W-1:0] !== want.value) begin
						$display("%0t: mode_value expected %h, got %h", $time, want.value,
							m_tdata[VALUE_W-1:0]);
						errors++;
					end
					if (m_tdata[VALUE_W +: CNT_W] !== want.count) begin
						$display("%0t: mode_count expected %0d, got %0d", $time, want.count,
							m_tdata[VALUE_W +: CNT_W]);
						errors++;
					end
					if (m_tdata[VALUE_W + CNT_W] !== want.overflow) begin
						$display("%0t: overflow expected %b, got %b", $time, want.overflow,
							m_tdata[VALUE_W + CNT_W]);
						errors++;
					end
					if (m_tdata[M_TDATA_W-1:OUT_W] !== '0) begin
						$display("%0t: padding expected 0, got %h", $time,
							m_tdata[M_TDATA_W-1:OUT_W]);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					stall_left = pick_idle();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : run_sets
		logic [VALUE_W-1:0] pool[80];
		logic [VALUE_W-1:0] v;
		int total_items;
		int random_items;
		int pool_n;
		int len;
		int pick;
		bit hold;

		// Single-value sets at both ends of the value range.
		add_value('0, 1'b1);
		add_value('1, 1'b1);
		// A tie goes to the value that reached the top count first.
		add_value(64'd5, 1'b0, 1'b1);
		add_value(64'd7, 1'b0);
		add_value(64'd7, 1'b0);
		add_value(64'd5, 1'b1);
		add_value({32{2'b10}}, 1'b0);
		add_value({32{2'b01}}, 1'b0);
		add_value({32{2'b01}}, 1'b1);
		add_value(64'h8000_0000_0000_0000, 1'b0);
		add_value(64'd1, 1'b0);
		add_value(64'h8000_0000_0000_0000, 1'b1);
		add_value(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		add_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		for (int k = 0; k < 4; k++)
			add_value(64'd3, k == 3);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			hold = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				pool_n = $urandom_range(DEF_DISTINCT_DEPTH - 4, DEF_DISTINCT_DEPTH + 8);
				for (int k = 0; k < pool_n; k++)
					pool[k] = rand_value();
				len = pool_n + $urandom_range(0, 30);
				for (int k = 0; k < len; k++) begin
					v = (k < pool_n) ? pool[k] : pool[$urandom_range(0, pool_n - 1)];
					add_value(v, k == len - 1, hold && k == 0);
				end
			end else begin
				pool_n = $urandom_range(1, 8);
				for (int k = 0; k < pool_n; k++) begin
					pick = $urandom_range(0, 9);
					if (k > 0 && pick < 3)
						pool[k] = pool[0] ^ (64'd1 << $urandom_range(0, VALUE_W - 1));
					else if (pick == 3)
						pool[k] = '0;
					else if (pick == 4)
						pool[k] = '1;
					else
						pool[k] = rand_value();
				end
				len = $urandom_range(1, 24);
				for (int k = 0; k < len; k++)
					add_value(pool[$urandom_range(0, pool_n - 1)], k == len - 1,
						hold && k == 0);
			end
			random_items += len;
		end

		total_items = values_to_send.size();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		while (values_sent < total_items || modes_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d values in %0d sets and checked %0d modes.", values_sent, sets_sent,
			results_seen);
		$display("%0d sets overran the table; ties and near-equal values were also covered.",
			overflow_sets);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/mfv_pkg.sv
hdl/mfv_table.sv
hdl/mfv_scan.sv
hdl/most_frequent_value_finder.sv
sim/most_frequent_value_finder_test.sv
